/* sv/piecewise_linear_table_interp_defines.svh */
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PLTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/plti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

  localparam int MaxPointsDef = 64;
  localparam int DataW        = 32;
  localparam int CountW       = 7;
  localparam int IndexW       = 6;
  localparam int TdataInW     = 72;
  localparam int CfgAddrW     = 3;

  // register index (paddr[2])
  localparam logic RegPointsInUse = 1'b0;

  localparam logic [CountW-1:0] PointsReset = 7'd1;

  // tuser on the input side
  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

endpackage

`default_nettype wire

/* sv/piecewise_linear_table_interp.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// s_axis    in   tdata: point_index[5:0] x_value[37:6] y_value[69:38]; tuser: mode
// m_axis    out  tdata: y_out[31:0]; tuser: in_range
// apb       in   reg 0 points_in_use at byte address 0
//
// For N breakpoints in use, a query makes two reads for the end points, one step per
// segment scanned (at most N - 1), then one multiply, 32 restoring divide steps, one
// add and one output load; an early result skips straight to the output load.
// Reset clears the sequencer and output valid; table contents are not cleared.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next one holds the sequencer until it goes.

module piecewise_linear_table_interp
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // tdata: point_index, x_value, y_value (low to high), zero pad
  input  wire logic [TdataInW-1:0] s_axis_tdata,
  // tuser: mode
  input  wire logic                s_axis_tuser,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: y_out
  output logic [DataW-1:0]         m_axis_tdata,
  // tuser: in_range
  output logic                     m_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

`include "piecewise_linear_table_interp_defines.svh"

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int NW  = (CW > CountW) ? CW : CountW;
  localparam int MW  = 2 * DataW;

  typedef enum logic [2:0] {
    S_IDLE, S_LAST, S_FIRST, S_SCAN, S_MUL, S_DIV, S_FIX, S_OUT
  } state_e;

  state_e                   state_q;
  logic [CountW-1:0]        points_q;
  logic [AW-1:0]            last_q, j_q;
  logic signed [DataW-1:0]  xq_q, xlast_q, px_q, py_q;
  logic [DataW-1:0]         dx_q, t_q, dymag_q;
  logic                     dyneg_q;
  logic [MW-1:0]            div_q;
  logic [$clog2(DataW)-1:0] cnt_q;
  logic [DataW-1:0]         res_y_q;
  logic                     res_ok_q;
  logic [DataW-1:0]         out_data_q;
  logic                     out_ok_q, out_valid_q;

  logic [MW-1:0]            mem [MAX_POINTS];
  logic [MW-1:0]            rd_q;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;

  logic                     in_xfer, out_xfer;
  logic [IndexW-1:0]        in_idx;
  logic signed [DataW-1:0]  in_x, in_y;
  logic [NW-1:0]            n_raw, n_clamp;
  logic signed [DataW-1:0]  cx, cy;
  logic signed [DataW:0]    dy;
  logic                     hit;
  logic [MW:0]              sh;
  logic [DataW:0]           top;
  logic                     qbit;
  logic [DataW:0]           top_sub;

  assign in_idx  = s_axis_tdata[IndexW-1:0];
  assign in_x    = s_axis_tdata[IndexW +: DataW];
  assign in_y    = s_axis_tdata[IndexW+DataW +: DataW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = out_valid_q && m_axis_tready;

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tvalid = out_valid_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPointsInUse) ? DataW'(points_q) : '0;

  // clamp point count into 1..MAX_POINTS
  assign n_raw = NW'(points_q);
  always_comb begin
    priority if (n_raw == '0) begin
      n_clamp = NW'(1);
    end else if (n_raw > NW'(MAX_POINTS)) begin
      n_clamp = NW'(MAX_POINTS);
    end else begin
      n_clamp = n_raw;
    end
  end

  assign mem_we = in_xfer && (s_axis_tuser == ModeLoad) &&
                  (NW'(in_idx) < NW'(MAX_POINTS));

  assign cx  = rd_q[DataW-1:0];
  assign cy  = rd_q[MW-1:DataW];
  assign dy  = {cy[DataW-1], cy} - {py_q[DataW-1], py_q};
  assign hit = (xq_q >= px_q) && (xq_q <= cx);

  // one restoring divide step: shared subtract and compare
  assign sh      = {div_q, 1'b0};
  assign top     = sh[MW:DataW];
  assign top_sub = top - {1'b0, dx_q};
  assign qbit    = (top >= {1'b0, dx_q});

  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_addr = AW'(n_clamp - NW'(1));
      S_LAST:  rd_addr = '0;
      S_FIRST: rd_addr = AW'(1);
      S_SCAN:  rd_addr = j_q + AW'(1);
      default: rd_addr = j_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(in_idx)] <= {in_y, in_x};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= PointsReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegPointsInUse)) begin
      points_q <= pwdata[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // S_OUT refills the register on its own transfer
      if (out_xfer && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && (s_axis_tuser == ModeQuery)) begin
            xq_q    <= in_x;
            last_q  <= AW'(n_clamp - NW'(1));
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          xlast_q <= cx;
          state_q <= S_FIRST;
        end
        S_FIRST: begin
          px_q <= cx;
          py_q <= cy;
          j_q  <= AW'(1);
          if ((xq_q < cx) || (xq_q > xlast_q)) begin
            res_y_q  <= '0;
            res_ok_q <= 1'b0;
            state_q  <= S_OUT;
          end else if (last_q == '0) begin
            res_y_q  <= cy;
            res_ok_q <= 1'b1;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            dx_q     <= cx - px_q;
            t_q      <= xq_q - px_q;
            dyneg_q  <= dy[DataW];
            dymag_q  <= dy[DataW] ? DataW'(-dy) : dy[DataW-1:0];
            res_ok_q <= 1'b1;
            if (cx == px_q) begin
              res_y_q <= py_q;
              state_q <= S_OUT;
            end else begin
              state_q <= S_MUL;
            end
          end else begin
            px_q <= cx;
            py_q <= cy;
            if (j_q == last_q) begin
              res_y_q  <= '0;
              res_ok_q <= 1'b0;
              state_q  <= S_OUT;
            end else begin
              j_q <= j_q + AW'(1);
            end
          end
        end
        S_MUL: begin
          div_q   <= dymag_q * t_q;
          cnt_q   <= '1;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // quotient fits in the low half since t <= dx
          div_q <= {(qbit ? top_sub[DataW-1:0] : top[DataW-1:0]), sh[DataW-1:1], qbit};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          res_y_q <= dyneg_q ? (py_q - div_q[DataW-1:0]) : (py_q + div_q[DataW-1:0]);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_y_q;
            out_ok_q    <= res_ok_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PLTI_ASSERT_NOW(a_rem_below_divisor, state_q == S_DIV,
                   div_q[MW-1:DataW] < dx_q, "divide remainder not below divisor")
  `PLTI_ASSERT_NEXT(a_mul_fits, state_q == S_MUL,
                    div_q[MW-1:DataW] < dx_q, "product high half not below divisor")
  `PLTI_ASSERT_NOW(a_oor_zero, out_valid_q && !out_ok_q,
                   out_data_q == '0, "out-of-range result carries data")
  `PLTI_ASSERT_NEXT(a_load_no_result,
                    in_xfer && (s_axis_tuser == ModeLoad) && !out_valid_q,
                    !out_valid_q, "load produced a result")

endmodule

`default_nettype wire

/* tb/piecewise_linear_table_interp_checker.sv */
`timescale 1ns / 1ps

module piecewise_linear_table_interp_checker
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: point_index, x_value, y_value (low to high)
  input  logic [TdataInW-1:0] s_tdata_i,
  // tuser: mode
  input  logic                s_tuser_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // tdata: y_out
  input  logic [DataW-1:0]    m_tdata_i,
  // tuser: in_range
  input  logic                m_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [DataW-1:0]    pwdata_i,
  input  logic                pready_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [DataW-1:0] y_out;
    logic             in_range;
  } interp_result_t;

  logic signed [DataW-1:0] bp_x [MAX_POINTS];
  logic signed [DataW-1:0] bp_y [MAX_POINTS];
  logic [CountW-1:0]       points_in_use;
  interp_result_t          predicted_y_q [$];
  int                      mismatches;

  function automatic interp_result_t interp_at(logic signed [DataW-1:0] xq);
    interp_result_t    res;
    int                n;
    bit                found;
    longint            xv, x0, x1, y0, dy, y;
    longint unsigned   t, dx, mdy, q;
    res   = '0;
    found = 1'b0;
    n     = points_in_use;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    xv = xq;
    x0 = bp_x[0];
    x1 = bp_x[n-1];
    if (xv >= x0 && xv <= x1) begin
      if (n == 1) begin
        res.y_out    = bp_y[0];
        res.in_range = 1'b1;
      end else begin
        // first segment holding x wins
        for (int j = 0; j < n - 1; j++) begin
          x0 = bp_x[j];
          x1 = bp_x[j+1];
          if (!found && xv >= x0 && xv <= x1) begin
            found = 1'b1;
            y0    = bp_y[j];
            if (x1 == x0) begin
              y = y0;
            end else begin
              dy  = bp_y[j+1];
              dy  = dy - y0;
              mdy = (dy < 0) ? -dy : dy;
              t   = xv - x0;
              dx  = x1 - x0;
              q   = (mdy * t) / dx;
              y   = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
            end
            res.y_out    = y[DataW-1:0];
            res.in_range = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    interp_result_t got, want;
    if (!rst_ni) begin
      points_in_use <= PointsReset;
      predicted_y_q.delete();
      mismatches    = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == RegPointsInUse) begin
        points_in_use <= pwdata_i[CountW-1:0];
      end
      if (m_tvalid_i && m_tready_i) begin
        got.y_out    = m_tdata_i;
        got.in_range = m_tuser_i;
        if (predicted_y_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: y_out=%h in_range=%b",
                     got.y_out, got.in_range);
          mismatches++;
        end else begin
          want = predicted_y_q.pop_front();
          if (got.y_out !== want.y_out || got.in_range !== want.in_range) begin
            if (mismatches < 10)
              $display("mismatch: expected y_out=%h in_range=%b, got y_out=%h in_range=%b",
                       want.y_out, want.in_range, got.y_out, got.in_range);
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == ModeLoad) begin
          bp_x[s_tdata_i[IndexW-1:0]] <= s_tdata_i[IndexW +: DataW];
          bp_y[s_tdata_i[IndexW-1:0]] <= s_tdata_i[IndexW+DataW +: DataW];
        end else begin
          predicted_y_q.push_back(interp_at(s_tdata_i[IndexW +: DataW]));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= predicted_y_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import plti_pkg::*;

  localparam int     HalfPeriod    = 5;
  localparam int     ResetCycles   = 3;
  localparam int     SettleCycles  = 120;
  localparam int     HoldCycles    = 400;
  localparam int     WatchdogLimit = 4000;
  localparam int     QueriesPerSet = 60;
  localparam longint XHi           = 64'sh7FFF_FFFF;
  localparam longint XLo           = -XHi - 1;
  localparam logic [CfgAddrW-1:0] PointsAddr = {RegPointsInUse, 2'b00};
  localparam logic [CfgAddrW-1:0] UnusedAddr = {~RegPointsInUse, 2'b00};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [TdataInW-1:0] s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  int src_idle_pct  = 22;
  int sink_idle_pct = 50;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int fail_count;
  int pending;

  // x of each slot as last loaded, used to aim queries at the table span
  logic signed [DataW-1:0] x_mirror [MaxPointsDef];

  always #HalfPeriod clk = ~clk;

  piecewise_linear_table_interp DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  piecewise_linear_table_interp_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served   <= hold_reqs;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic mode, logic [IndexW-1:0] idx,
                           logic [DataW-1:0] xv, logic [DataW-1:0] yv);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(TdataInW-IndexW-2*DataW){1'b0}}, yv, xv, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic load_point(int idx, logic [DataW-1:0] xv, logic [DataW-1:0] yv);
    x_mirror[idx] = xv;
    send_item(ModeLoad, idx[IndexW-1:0], xv, yv);
  endtask

  task automatic query_at(logic [DataW-1:0] xv);
    logic [IndexW-1:0] junk_idx;
    logic [DataW-1:0]  junk_y;
    junk_idx = IndexW'($urandom);
    junk_y   = $urandom;
    send_item(ModeQuery, junk_idx, xv, junk_y);
  endtask

  // wait for every outstanding result, then for a query's worth of cycles
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_points(int n);
    settle();
    write_reg(PointsAddr, n);
  endtask

  // ascending x with random spacing; some zero-length steps, saturating at the top
  task automatic load_table(int neff);
    longint           xcur;
    int               b;
    logic [DataW-1:0] yv;
    case ($urandom_range(3))
      0:       xcur = XLo;
      1:       xcur = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: xcur = int'($urandom);
    endcase
    b = $urandom_range(26);
    for (int k = 0; k < neff; k++) begin
      if (k > 0 && $urandom_range(9) != 0) xcur = xcur + ($urandom & ((1 << b) - 1));
      if (xcur > XHi) xcur = XHi;
      if (k == neff - 1 && $urandom_range(7) == 0) xcur = XHi;
      yv = $urandom;
      case ($urandom_range(9))
        0: yv = 32'h8000_0000;
        1: yv = 32'h7FFF_FFFF;
        default: ;
      endcase
      load_point(k, xcur[DataW-1:0], yv);
    end
  endtask

  function automatic logic [DataW-1:0] pick_query_x(int neff);
    longint lo, hi, xq;
    int     r;
    lo = x_mirror[0];
    hi = x_mirror[neff-1];
    r  = $urandom_range(99);
    if (r < 12) begin
      if ($urandom_range(1) == 1) xq = lo - 1 - $urandom_range(65535);
      else xq = hi + 1 + $urandom_range(65535);
      if (xq < XLo) xq = XLo;
      if (xq > XHi) xq = XHi;
    end else if (r < 16 || hi < lo) begin
      xq = int'($urandom);
    end else if (r < 30) begin
      xq = x_mirror[$urandom_range(neff - 1)];
    end else begin
      xq = lo + ({$urandom, $urandom} % (hi - lo + 1));
    end
    return xq[DataW-1:0];
  endfunction

  initial begin : stimulus
    int n, neff;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-point table straight after reset
    load_point(0, 32'h0001_0000, 32'h7FFF_FFFF);
    query_at(32'h0001_0000);
    query_at(32'h0001_0001);
    query_at(32'h0000_FFFF);
    // a count of zero behaves as one
    set_points(0);
    query_at(32'h0001_0000);
    // full-scale span in both x and y
    load_point(0, 32'h8000_0000, 32'h7FFF_FFFF);
    load_point(1, 32'h7FFF_FFFF, 32'h8000_0000);
    set_points(2);
    query_at(32'h8000_0000);
    query_at(32'h7FFF_FFFF);
    query_at(32'h0000_0000);
    query_at(32'h1234_5678);
    // zero-length first segment, then a falling one
    load_point(0, 32'hFFFB_0000, 32'h0000_0003);
    load_point(1, 32'hFFFB_0000, 32'h0000_0009);
    load_point(2, 32'h0007_0000, 32'hFF9C_0000);
    set_points(3);
    query_at(32'hFFFB_0000);
    query_at(32'h0001_0000);
    query_at(32'h0007_0000);
    query_at(32'h0007_0001);
    // table no longer ascending
    load_point(1, 32'h000A_0000, 32'h0000_0000);
    query_at(32'h0008_0000);
    query_at(32'h000A_0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct <= 50;
        end
        1: begin
          src_idle_pct  = 50;
          sink_idle_pct <= 22;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
        end
      endcase
      for (int s = 0; s < 5; s++) begin
        case (s)
          0: n = 1;
          1: n = 2;
          2: n = $urandom_range(3, 63);
          3: n = MaxPointsDef;
          default: n = (phase == 0) ? 0 : (phase == 1) ? 127 : $urandom_range(65, 127);
        endcase
        neff = (n < 1) ? 1 : (n > MaxPointsDef) ? MaxPointsDef : n;
        set_points(n);
        if (s == 4) write_reg(UnusedAddr, $urandom);
        load_table(neff);
        // long result stall while queries keep coming, so the input backs up
        if (s == 3) hold_reqs <= hold_reqs + 1;
        repeat (QueriesPerSet) begin
          if ($urandom_range(99) < 8) load_point($urandom_range(63), $urandom, $urandom);
          else query_at(pick_query_x(neff));
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* piecewise_linear_table_interp.f */
+incdir+sv
sv/plti_pkg.sv
sv/piecewise_linear_table_interp.sv
tb/piecewise_linear_table_interp_checker.sv
tb/tb.sv
